// ----- rtl/dbrt_pkg.sv -----
package dbrt_pkg;

  localparam int NumSlotsDef = 4;
  localparam int CfgSlots    = 4;
  localparam int MsPerSec    = 1000;
  localparam int AddrW       = 6;
  localparam int DataW       = 64;
  localparam logic [15:0] DebounceRst = 16'd50;

  typedef enum logic [2:0] {
    ST_UNKNOWN = 3'd0,
    ST_PRESS   = 3'd1,
    ST_HELD    = 3'd2,
    ST_RELEASE = 3'd3,
    ST_IDLE    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_BEGIN   = 3'd1,
    CMD_END     = 3'd2,
    CMD_INSIDE  = 3'd3,
    CMD_OUTSIDE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SIGNAL_ENABLE = 3'd0,
    REG_SIGNAL_MODE   = 3'd1,
    REG_PRESSED_LEVEL = 3'd2,
    REG_DEBOUNCE_MS   = 3'd3,
    REG_SLOT_ENABLE   = 3'd4,
    REG_SLOT_RELAYS   = 3'd5,
    REG_SLOT_SECONDS  = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_ONE  = 2'd1,
    S_SCAN = 2'd2
  } state_e;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    status_e     button_status;
    logic [1:0]  slot_index;
    logic [7:0]  relay_id;
    cmd_e        relay_command;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic        signal_enable;
    logic        signal_mode;
    logic        pressed_level;
    logic [15:0] debounce_ms;
    logic [3:0]  slot_enable_mask;
    logic [31:0] slot_relay_ids;
    logic [63:0] slot_seconds;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic emit_one;
    logic emit_slot;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic enable;
    logic any_slot;
    logic cur_en;
    logic cur_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- rtl/dbrt_regs.sv -----
module dbrt_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbrt_pkg::AddrW-1:0]    paddr,
  input  logic [dbrt_pkg::DataW-1:0]    pwdata,
  output logic [dbrt_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output dbrt_pkg::cfg_t                cfg_o
);

  dbrt_pkg::cfg_t     cfg_q, cfg_d;
  dbrt_pkg::reg_idx_e idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = dbrt_pkg::reg_idx_e'(paddr[dbrt_pkg::AddrW-1:3]);
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        dbrt_pkg::REG_SIGNAL_ENABLE: cfg_d.signal_enable    = pwdata[0];
        dbrt_pkg::REG_SIGNAL_MODE:   cfg_d.signal_mode      = pwdata[0];
        dbrt_pkg::REG_PRESSED_LEVEL: cfg_d.pressed_level    = pwdata[0];
        dbrt_pkg::REG_DEBOUNCE_MS:   cfg_d.debounce_ms      = pwdata[15:0];
        dbrt_pkg::REG_SLOT_ENABLE:   cfg_d.slot_enable_mask = pwdata[3:0];
        dbrt_pkg::REG_SLOT_RELAYS:   cfg_d.slot_relay_ids   = pwdata[31:0];
        dbrt_pkg::REG_SLOT_SECONDS:  cfg_d.slot_seconds     = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dbrt_pkg::REG_SIGNAL_ENABLE: prdata = 64'(cfg_q.signal_enable);
      dbrt_pkg::REG_SIGNAL_MODE:   prdata = 64'(cfg_q.signal_mode);
      dbrt_pkg::REG_PRESSED_LEVEL: prdata = 64'(cfg_q.pressed_level);
      dbrt_pkg::REG_DEBOUNCE_MS:   prdata = 64'(cfg_q.debounce_ms);
      dbrt_pkg::REG_SLOT_ENABLE:   prdata = 64'(cfg_q.slot_enable_mask);
      dbrt_pkg::REG_SLOT_RELAYS:   prdata = 64'(cfg_q.slot_relay_ids);
      dbrt_pkg::REG_SLOT_SECONDS:  prdata = cfg_q.slot_seconds;
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{debounce_ms: dbrt_pkg::DebounceRst, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/dbrt_ctrl.sv -----
module dbrt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dbrt_pkg::ctrl_sts_t   sts_i,
  output dbrt_pkg::ctrl_cmd_t   cmd_o
);

  dbrt_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dbrt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (sts_i.enable && sts_i.any_slot) ? dbrt_pkg::S_SCAN : dbrt_pkg::S_ONE;
        end
      end
      dbrt_pkg::S_ONE: begin
        if (sts_i.out_free) state_d = dbrt_pkg::S_IDLE;
      end
      dbrt_pkg::S_SCAN: begin
        if (sts_i.cur_en && sts_i.out_free && sts_i.cur_last) state_d = dbrt_pkg::S_IDLE;
      end
      default: state_d = dbrt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      dbrt_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.start = in_valid_i;
      end
      dbrt_pkg::S_ONE: begin
        cmd_o.emit_one = sts_i.out_free;
      end
      dbrt_pkg::S_SCAN: begin
        cmd_o.emit_slot = sts_i.cur_en & sts_i.out_free;
        cmd_o.advance   = ~sts_i.cur_en | sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbrt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/dbrt_dp.sv -----
module dbrt_dp #(
  parameter int NUM_SLOTS = dbrt_pkg::NumSlotsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dbrt_pkg::cfg_t        cfg_i,
  input  dbrt_pkg::in_t         in_item_i,
  input  dbrt_pkg::ctrl_cmd_t   cmd_i,
  output dbrt_pkg::ctrl_sts_t   sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dbrt_pkg::res_t        out_item_o
);

  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0] en_a;
  logic [7:0]           relay_a [NUM_SLOTS];
  logic [15:0]          secs_a  [NUM_SLOTS];

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot_cfg
    if (g < dbrt_pkg::CfgSlots) begin : g_on
      assign en_a[g]    = cfg_i.slot_enable_mask[g];
      assign relay_a[g] = cfg_i.slot_relay_ids[8*g +: 8];
      assign secs_a[g]  = cfg_i.slot_seconds[16*g +: 16];
    end else begin : g_off
      assign en_a[g]    = 1'b0;
      assign relay_a[g] = '0;
      assign secs_a[g]  = '0;
    end
  end

  logic                 stable_q, stable_d;
  logic [31:0]          stamp_q, stamp_d;
  logic [31:0]          window_q, window_d;
  logic [31:0]          now_q;
  dbrt_pkg::status_e    st_q, st_c;
  logic                 any_q, any_c;
  logic [SlotW-1:0]     cnt_q, cnt_d;
  logic [31:0]          end_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] run_q, run_d;
  logic                 out_valid_q, out_valid_d;
  dbrt_pkg::res_t       out_q, out_d;

  logic                 pressed;
  logic [31:0]          elapsed;
  logic                 cur_last;
  logic [25:0]          len_ms;
  logic [31:0]          restart_end;
  logic [31:0]          cur_end;
  logic                 cur_run;
  logic                 in_window;
  dbrt_pkg::cmd_e       slot_cmd;
  logic                 slot_run_d;
  logic                 slot_end_wr;
  logic [31:0]          slot_end_d;
  logic                 out_free;

  // debounce
  assign pressed = (in_item_i.pin_level == cfg_i.pressed_level);
  assign elapsed = in_item_i.now_ms - stamp_q;

  always_comb begin
    stable_d = stable_q;
    stamp_d  = stamp_q;
    if (pressed == stable_q) begin
      stamp_d = in_item_i.now_ms;
      st_c    = pressed ? dbrt_pkg::ST_HELD : dbrt_pkg::ST_IDLE;
    end else if (elapsed > 32'(cfg_i.debounce_ms)) begin
      stable_d = pressed;
      stamp_d  = in_item_i.now_ms;
      st_c     = pressed ? dbrt_pkg::ST_PRESS : dbrt_pkg::ST_RELEASE;
    end else begin
      st_c     = stable_q ? dbrt_pkg::ST_HELD : dbrt_pkg::ST_IDLE;
    end
    window_d = (st_c != dbrt_pkg::ST_IDLE) ? in_item_i.now_ms : window_q;
    any_c    = (st_c == dbrt_pkg::ST_PRESS) && cfg_i.signal_mode && |(en_a & run_q);
  end

  // current slot
  always_comb begin
    cur_last = 1'b1;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if ((j > int'(cnt_q)) && en_a[j]) cur_last = 1'b0;
    end
  end

  assign len_ms      = 26'(secs_a[cnt_q]) * 26'(dbrt_pkg::MsPerSec);
  assign restart_end = window_q + 32'(len_ms);
  assign cur_end     = end_q[cnt_q];
  assign cur_run     = run_q[cnt_q];
  assign in_window   = (window_q < cur_end) ?
                       ((now_q >= window_q) && (now_q < cur_end)) :
                       ((now_q >= window_q) || (now_q < cur_end));

  always_comb begin
    slot_cmd    = dbrt_pkg::CMD_NONE;
    slot_run_d  = cur_run;
    slot_end_wr = 1'b0;
    slot_end_d  = restart_end;
    case (st_q)
      dbrt_pkg::ST_PRESS: begin
        if (!cfg_i.signal_mode || !any_q) begin
          slot_cmd    = dbrt_pkg::CMD_BEGIN;
          slot_run_d  = 1'b1;
          slot_end_wr = 1'b1;
        end else if (cur_run) begin
          slot_cmd    = dbrt_pkg::CMD_END;
          slot_run_d  = 1'b0;
          slot_end_wr = 1'b1;
          slot_end_d  = window_q;
        end
      end
      dbrt_pkg::ST_HELD, dbrt_pkg::ST_RELEASE: begin
        if (!cfg_i.signal_mode) begin
          slot_cmd    = dbrt_pkg::CMD_INSIDE;
          slot_run_d  = 1'b1;
          slot_end_wr = 1'b1;
        end else begin
          slot_cmd = cur_run ? dbrt_pkg::CMD_INSIDE : dbrt_pkg::CMD_OUTSIDE;
        end
      end
      dbrt_pkg::ST_IDLE: begin
        if (!cur_run) begin
          slot_cmd = dbrt_pkg::CMD_OUTSIDE;
        end else if (in_window) begin
          slot_cmd = dbrt_pkg::CMD_INSIDE;
        end else begin
          slot_cmd   = dbrt_pkg::CMD_END;
          slot_run_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    if (cmd_i.emit_one) begin
      out_valid_d         = 1'b1;
      out_d.button_status = st_q;
      out_d.slot_index    = '0;
      out_d.relay_id      = '0;
      out_d.relay_command = dbrt_pkg::CMD_NONE;
      out_d.last_result   = 1'b1;
    end else if (cmd_i.emit_slot) begin
      out_valid_d         = 1'b1;
      out_d.button_status = st_q;
      out_d.slot_index    = 2'(cnt_q);
      out_d.relay_id      = relay_a[cnt_q];
      out_d.relay_command = slot_cmd;
      out_d.last_result   = cur_last;
    end
  end

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      cnt_d = '0;
    end else if (cmd_i.advance) begin
      cnt_d = cnt_q + SlotW'(1);
    end
    if (cmd_i.emit_slot) run_d[cnt_q] = slot_run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q    <= 1'b0;
      stamp_q     <= '0;
      window_q    <= '0;
      run_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start && cfg_i.signal_enable) begin
        stable_q <= stable_d;
        stamp_q  <= stamp_d;
        window_q <= window_d;
      end
      run_q       <= run_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      now_q <= in_item_i.now_ms;
      st_q  <= cfg_i.signal_enable ? st_c : dbrt_pkg::ST_UNKNOWN;
      any_q <= any_c;
    end
    if (cmd_i.emit_slot && slot_end_wr) end_q[cnt_q] <= slot_end_d;
    out_q <= out_d;
  end

  assign sts_o.enable   = cfg_i.signal_enable;
  assign sts_o.any_slot = |en_a;
  assign sts_o.cur_en   = en_a[cnt_q];
  assign sts_o.cur_last = cur_last;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/debounced_button_relay_timers_top.sv -----
// sequence: an accepted tick has its debounce status registered, then the scan
// state loads a beat per enabled slot into the output register, skipping disabled ones
// throughput: one slot per cycle through the shared slot evaluation unless the output
// stalls; a single beat when disabled or no slot enabled; new tick taken once idle
// reset: debounce state, window start and running flags clear at once, registers
// take their defaults; no clearing pass, a tick can be accepted right after reset
module debounced_button_relay_timers_top #(
  parameter int NUM_SLOTS = dbrt_pkg::NumSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbrt_pkg::AddrW-1:0]    paddr,
  input  logic [dbrt_pkg::DataW-1:0]    pwdata,
  output logic [dbrt_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dbrt_pkg::in_t                 in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dbrt_pkg::res_t                out_item_o
);

  dbrt_pkg::cfg_t      cfg;
  dbrt_pkg::ctrl_cmd_t cmd;
  dbrt_pkg::ctrl_sts_t sts;

  dbrt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dbrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbrt_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- tb/sv/debounced_button_relay_timers_top_tb.sv -----
module debounced_button_relay_timers_top_tb;
  import dbrt_pkg::*;

  localparam int SqueezeLen = 320;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_t              in_item_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  res_t             out_item_o;

  debounced_button_relay_timers_top dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

  always #2 clk_i = ~clk_i;

  // shadow of the register file and of the button / timer state
  cfg_t        cfg_sh;
  logic        btn_down = 1'b0;
  logic [31:0] bounce_stamp = '0;
  logic [31:0] win_start = '0;
  logic [31:0] slot_end [CfgSlots] = '{default: '0};
  logic        slot_live [CfgSlots] = '{default: 1'b0};

  in_t  tick_q[$];
  res_t due_cmds[$];

  int   misses = 0;
  int   ticks_done = 0;
  int   beats_seen = 0;
  int   settings_loaded = 0;
  int   gap_left = 0;
  int   wait_left = 0;
  int   hold_left = 0;
  bit   calm_tx = 1'b0;
  bit   calm_rx = 1'b0;
  bit   squeeze_req = 1'b0;
  bit   squeeze_done = 1'b0;
  logic raw_pin = 1'b0;
  logic [31:0] clock_ms = '0;

  function automatic logic [31:0] slot_ms(int i);
    return 32'(cfg_sh.slot_seconds[16*i +: 16]) * 32'(MsPerSec);
  endfunction

  function automatic void rearm(int i);
    slot_end[i] = win_start + slot_ms(i);
    slot_live[i] = 1'b1;
  endfunction

  function automatic void relay_commands_for(in_t tick);
    res_t        beats[$];
    res_t        r;
    status_e     st;
    cmd_e        cmd;
    logic        pressed;
    logic        any_live;
    logic        in_window;
    logic [31:0] elapsed;
    logic [31:0] s;
    logic [31:0] e;
    if (!cfg_sh.signal_enable) begin
      r = '{button_status: ST_UNKNOWN, slot_index: 2'd0, relay_id: 8'd0,
            relay_command: CMD_NONE, last_result: 1'b1};
      due_cmds.push_back(r);
      return;
    end
    pressed = (tick.pin_level == cfg_sh.pressed_level);
    elapsed = tick.now_ms - bounce_stamp;
    if (pressed == btn_down) begin
      bounce_stamp = tick.now_ms;
      st = pressed ? ST_HELD : ST_IDLE;
    end else if (elapsed > 32'(cfg_sh.debounce_ms)) begin
      btn_down = pressed;
      bounce_stamp = tick.now_ms;
      st = pressed ? ST_PRESS : ST_RELEASE;
    end else begin
      st = btn_down ? ST_HELD : ST_IDLE;
    end
    if (st != ST_IDLE) win_start = tick.now_ms;
    any_live = 1'b0;
    for (int i = 0; i < CfgSlots; i++) begin
      if (cfg_sh.slot_enable_mask[i] && slot_live[i]) any_live = 1'b1;
    end
    for (int i = 0; i < CfgSlots; i++) begin
      if (cfg_sh.slot_enable_mask[i]) begin
        cmd = CMD_NONE;
        case (st)
          ST_PRESS: begin
            if (!cfg_sh.signal_mode || !any_live) begin
              rearm(i);
              cmd = CMD_BEGIN;
            end else if (slot_live[i]) begin
              slot_end[i] = win_start;
              slot_live[i] = 1'b0;
              cmd = CMD_END;
            end
          end
          ST_HELD, ST_RELEASE: begin
            if (!cfg_sh.signal_mode) begin
              rearm(i);
              cmd = CMD_INSIDE;
            end else begin
              cmd = slot_live[i] ? CMD_INSIDE : CMD_OUTSIDE;
            end
          end
          default: begin
            if (!slot_live[i]) begin
              cmd = CMD_OUTSIDE;
            end else begin
              s = win_start;
              e = slot_end[i];
              // end at or before start means the window wraps
              in_window = (s < e) ? (tick.now_ms >= s && tick.now_ms < e)
                                  : (tick.now_ms >= s || tick.now_ms < e);
              if (in_window) begin
                cmd = CMD_INSIDE;
              end else begin
                slot_live[i] = 1'b0;
                cmd = CMD_END;
              end
            end
          end
        endcase
        r = '{button_status: st, slot_index: 2'(i), relay_id: cfg_sh.slot_relay_ids[8*i +: 8],
              relay_command: cmd, last_result: 1'b0};
        beats.push_back(r);
      end
    end
    if (beats.size() == 0) begin
      r = '{button_status: st, slot_index: 2'd0, relay_id: 8'd0,
            relay_command: CMD_NONE, last_result: 1'b1};
      beats.push_back(r);
    end
    beats[beats.size()-1].last_result = 1'b1;
    foreach (beats[k]) due_cmds.push_back(beats[k]);
  endfunction

  task automatic flag_miss(string msg);
    if (misses < 100) $display("mismatch: %s", msg);
    misses++;
  endtask

  task automatic check_beat(res_t got);
    res_t want;
    if (due_cmds.size() == 0) begin
      flag_miss($sformatf("beat %0d arrived with nothing pending: %h", beats_seen, got));
      return;
    end
    want = due_cmds.pop_front();
    if (got.button_status !== want.button_status || got.slot_index !== want.slot_index ||
        got.relay_id !== want.relay_id || got.relay_command !== want.relay_command ||
        got.last_result !== want.last_result)
      flag_miss($sformatf(
                  "beat %0d: status %0d/%0d slot %0d/%0d relay %h/%h cmd %0d/%0d last %b/%b",
                  beats_seen, got.button_status, want.button_status,
                  got.slot_index, want.slot_index, got.relay_id, want.relay_id,
                  got.relay_command, want.relay_command,
                  got.last_result, want.last_result));
  endtask

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic v;
    in_t  d;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
      gap_left = 0;
    end else begin
      v = in_valid_i;
      d = in_item_i;
      if (in_valid_i && !in_stall_o) begin
        relay_commands_for(in_item_i);
        ticks_done++;
        v = 1'b0;
        gap_left = calm_tx ? 0 : $urandom_range(0, 18);
      end
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_q.size() > 0) begin
          d = tick_q.pop_front();
          v = 1'b1;
        end
      end
      in_valid_i <= v;
      in_item_i <= d;
    end
  end

  // relay command monitor
  always @(posedge clk_i or negedge rst_ni) begin
    logic hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      wait_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_beat(out_item_o);
        beats_seen++;
        wait_left = calm_rx ? 0 : $urandom_range(0, 18);
      end
      if (squeeze_req && !squeeze_done) begin
        hold_left = SqueezeLen;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold = 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        hold = 1'b1;
      end else begin
        hold = 1'b0;
      end
      out_stall_i <= hold;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SIGNAL_ENABLE: cfg_sh.signal_enable = val[0];
      REG_SIGNAL_MODE:   cfg_sh.signal_mode = val[0];
      REG_PRESSED_LEVEL: cfg_sh.pressed_level = val[0];
      REG_DEBOUNCE_MS:   cfg_sh.debounce_ms = val[15:0];
      REG_SLOT_ENABLE:   cfg_sh.slot_enable_mask = val[3:0];
      REG_SLOT_RELAYS:   cfg_sh.slot_relay_ids = val[31:0];
      REG_SLOT_SECONDS:  cfg_sh.slot_seconds = val;
      default: ;
    endcase
  endtask

  task automatic load_cfg(cfg_t c);
    write_reg(REG_SIGNAL_ENABLE, 64'(c.signal_enable));
    write_reg(REG_SIGNAL_MODE, 64'(c.signal_mode));
    write_reg(REG_PRESSED_LEVEL, 64'(c.pressed_level));
    write_reg(REG_DEBOUNCE_MS, 64'(c.debounce_ms));
    write_reg(REG_SLOT_ENABLE, 64'(c.slot_enable_mask));
    write_reg(REG_SLOT_RELAYS, 64'(c.slot_relay_ids));
    write_reg(REG_SLOT_SECONDS, c.slot_seconds);
    settings_loaded++;
  endtask

  task automatic settle();
    while (tick_q.size() > 0 || in_valid_i || due_cmds.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic tick_after(logic pin, int unsigned dt);
    in_t t;
    clock_ms += dt;
    t.pin_level = pin;
    t.now_ms = clock_ms;
    tick_q.push_back(t);
  endtask

  // clean level changes past the debounce time, steady ticks, some glitches and time jumps
  task automatic wander(int count);
    int unsigned deb;
    repeat (count) begin
      deb = cfg_sh.debounce_ms;
      case ($urandom_range(0, 9))
        0, 1: tick_after(~raw_pin, $urandom_range(0, deb / 2));
        2, 3, 4: begin
          raw_pin = ~raw_pin;
          tick_after(raw_pin, deb + 1 + $urandom_range(0, 300));
        end
        9: tick_after(raw_pin, $urandom);
        default: tick_after(raw_pin, $urandom_range(0, 1500));
      endcase
    end
  endtask

  function automatic cfg_t pick_cfg(int flavor);
    cfg_t c;
    c.signal_enable = 1'b1;
    c.signal_mode = 1'($urandom_range(0, 1));
    c.pressed_level = 1'($urandom_range(0, 1));
    c.debounce_ms = 16'($urandom_range(0, 120));
    c.slot_enable_mask = 4'($urandom_range(0, 15));
    c.slot_relay_ids = $urandom;
    for (int i = 0; i < CfgSlots; i++)
      c.slot_seconds[16*i +: 16] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 3));
    if (flavor == 1) begin
      c.debounce_ms = '1;
      c.slot_enable_mask = '1;
      c.slot_relay_ids = '1;
      c.slot_seconds = '1;
    end else if (flavor == 2) begin
      c.debounce_ms = '0;
      c.slot_enable_mask = '1;
      c.slot_relay_ids = '0;
      c.slot_seconds = '0;
    end
    return c;
  endfunction

  initial begin
    cfg_t c;
    cfg_sh = '0;
    cfg_sh.debounce_ms = DebounceRst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // block still disabled from reset
    tick_after(1'b0, 0);
    tick_after(1'b1, 32'hFFFF_FFFF);
    settle();

    // enabled, no slot in use
    c = '0;
    c.signal_enable = 1'b1;
    c.pressed_level = 1'b1;
    c.slot_relay_ids = 32'h1234_5678;
    load_cfg(c);
    tick_after(1'b1, 11);
    tick_after(1'b1, 1);
    tick_after(1'b0, 1);
    tick_after(1'b0, 1);
    settle();

    // restart mode, all slots, window wrapping past zero
    c.debounce_ms = 16'd5;
    c.slot_enable_mask = 4'hF;
    c.slot_relay_ids = 32'hA5C3_0FF0;
    c.slot_seconds = 64'hFFFF_0002_0001_0000;
    load_cfg(c);
    clock_ms = 32'hFFFF_F000;
    tick_after(1'b0, 0);
    tick_after(1'b1, 10);
    tick_after(1'b0, 2);
    tick_after(1'b1, 3);
    tick_after(1'b0, 20);
    tick_after(1'b0, 500);
    tick_after(1'b0, 1200);
    tick_after(1'b0, 1000);
    settle();

    // toggle mode, inverted pin: cancel with idle slots, then start all
    write_reg(REG_SIGNAL_MODE, 64'd1);
    write_reg(REG_PRESSED_LEVEL, 64'd0);
    tick_after(1'b1, 10);
    tick_after(1'b0, 10);
    tick_after(1'b1, 10);
    tick_after(1'b0, 10);
    tick_after(1'b0, 10);
    settle();

    raw_pin = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      c = pick_cfg(ph == 1 ? 1 : (ph == 4 ? 2 : 0));
      calm_tx = ($urandom_range(0, 3) == 0);
      calm_rx = ($urandom_range(0, 3) == 0);
      load_cfg(c);
      if (ph == 2) begin
        calm_tx = 1'b1;
        squeeze_req = 1'b1;
      end
      if (ph == 3) begin
        wander(5);
        settle();
        write_reg(REG_SIGNAL_ENABLE, 64'd0);
        wander(6);
        settle();
        write_reg(REG_SIGNAL_ENABLE, 64'd1);
        wander(40);
      end else begin
        wander(45);
      end
      settle();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d ticks, %0d relay beats, %0d full register loads", ticks_done,
             beats_seen, settings_loaded);
    $display("includes a %0d-cycle receiver hold with ticks still arriving", SqueezeLen);
    if (misses == 0) begin
      $display("debounced_button_relay_timers_top regression: pass");
    end else begin
      $display("debounced_button_relay_timers_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("debounced_button_relay_timers_top regression: fail");
    $finish;
  end

endmodule

// ----- debounced_button_relay_timers_top.f -----
rtl/dbrt_pkg.sv
rtl/dbrt_regs.sv
rtl/dbrt_ctrl.sv
rtl/dbrt_dp.sv
rtl/debounced_button_relay_timers_top.sv
tb/sv/debounced_button_relay_timers_top_tb.sv
